// File: hw/rtl/dht_pkg.sv
// Package for the dense handle table: sizes, command and result beats,
// status codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dht_pkg;

    // table depth and the widths that follow from it
    localparam int MAX_ENTRIES = 64;
    localparam int SW = $clog2(MAX_ENTRIES);        // slot / map index width
    localparam int HW = $clog2(MAX_ENTRIES + 1);    // handle width (1-based)
    localparam int LW = $clog2(MAX_ENTRIES + 1);    // live count width

    typedef enum logic {
        KIND_ADD    = 1'b0,
        KIND_REMOVE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_UNKNOWN = 2'd2
    } t_status;

    // input beat
    typedef struct packed {
        t_kind           kind;
        logic [HW-1:0]   handle;
    } t_cmd;

    // result beat
    typedef struct packed {
        t_status         status;
        logic [HW-1:0]   given_handle;
        logic [SW-1:0]   slot;
        logic            moved;
        logic [HW-1:0]   moved_handle;
        logic [SW-1:0]   moved_from;
        logic [LW-1:0]   live_count;
    } t_res;

    // free handle search result
    typedef struct packed {
        logic            found;
        logic [SW-1:0]   idx;
    } t_free;

endpackage
`default_nettype wire

// File: hw/rtl/dht_free_enc.sv
// Lowest free handle finder: priority encoder over the in-use bitmap.
// Depends on dht_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dht_free_enc (
    input  wire logic [dht_pkg::MAX_ENTRIES-1:0] i_in_use,
    output dht_pkg::t_free                       o_free
);
    import dht_pkg::*;

    // scan from the top down so the lowest clear bit wins
    always_comb begin
        o_free = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!i_in_use[i]) begin
                o_free.found = 1'b1;
                o_free.idx   = SW'(i);
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/dense_handle_table.sv
// Dense handle table top level: handle/slot maps in two synchronous RAMs,
// in-use bitmap in flops. Depends on dht_pkg and dht_free_enc.
`timescale 1ns / 1ps
`default_nettype none
// An add, a refused add and a remove of an unknown handle stay in S_IDLE:
// busy stays low and the next command may follow at once. A remove of a
// live handle also passes through S_REMOVE, with busy high there, because the slot
// of the handle and the handle in the last slot come out of the two map
// RAMs as registered reads before the swap is written back.
// Every command gives exactly one result beat, strobed by o_res_valid for
// one cycle, from the result register after the command's last working state; the receiver
// cannot stall it. The maps need no clearing after reset: the table is
// ready as soon as reset is released.
module dense_handle_table (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire dht_pkg::t_cmd i_cmd,
    output logic               o_res_valid,
    output dht_pkg::t_res      o_res
);
    import dht_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_REMOVE
    } t_state;

    t_state                  r_state, n_state;
    logic [LW-1:0]           r_live, n_live;
    logic [MAX_ENTRIES-1:0]  r_in_use, n_in_use;
    logic                    r_res_valid, n_res_valid;
    t_res                    r_res, n_res;

    // latched remove context
    logic [SW-1:0]           r_hidx;
    logic [SW-1:0]           r_last;

    // map RAMs and their read data
    logic [HW-1:0]           mem_has [MAX_ENTRIES];   // handle at slot
    logic [SW-1:0]           mem_soh [MAX_ENTRIES];   // slot of handle
    logic [HW-1:0]           r_rd_lh;
    logic [SW-1:0]           r_rd_rem;

    logic                    has_we, soh_we;
    logic [SW-1:0]           has_addr, soh_addr;
    logic [HW-1:0]           has_data;
    logic [SW-1:0]           soh_data;

    t_free                   w_free;
    logic                    w_accept;
    logic [HW-1:0]           w_h_m1;
    logic [SW-1:0]           w_hidx;
    logic [LW-1:0]           w_live_m1;
    logic [SW-1:0]           w_last;
    logic                    w_rm_ok;
    logic                    w_add_ok;
    logic [HW-1:0]           w_lh_m1;
    logic                    w_moved;

    dht_free_enc u_free (
        .i_in_use (r_in_use),
        .o_free   (w_free)
    );

    // command decode
    assign w_accept  = start && !busy;
    assign w_h_m1    = i_cmd.handle - HW'(1);
    assign w_hidx    = w_h_m1[SW-1:0];
    assign w_live_m1 = r_live - LW'(1);
    assign w_last    = w_live_m1[SW-1:0];
    assign w_add_ok  = (r_live != LW'(MAX_ENTRIES)) && w_free.found;
    assign w_rm_ok   = (i_cmd.handle != '0) && (i_cmd.handle <= HW'(MAX_ENTRIES))
                       && r_in_use[w_hidx] && (r_live != '0);

    // swap decision in the S_REMOVE state
    assign w_lh_m1   = r_rd_lh - HW'(1);
    assign w_moved   = (r_rd_rem != r_last);

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // next state, map writes and result beat
    always_comb begin
        n_state     = r_state;
        n_live      = r_live;
        n_in_use    = r_in_use;
        n_res_valid = 1'b0;
        n_res       = r_res;
        has_we      = 1'b0;
        has_addr    = '0;
        has_data    = '0;
        soh_we      = 1'b0;
        soh_addr    = '0;
        soh_data    = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_cmd.kind == KIND_ADD) begin
                        n_res_valid      = 1'b1;
                        n_res            = '0;
                        n_res.live_count = r_live;
                        if (w_add_ok) begin
                            has_we   = 1'b1;
                            has_addr = r_live[SW-1:0];
                            has_data = HW'(w_free.idx) + HW'(1);
                            soh_we   = 1'b1;
                            soh_addr = w_free.idx;
                            soh_data = r_live[SW-1:0];
                            n_in_use[w_free.idx] = 1'b1;
                            n_live             = r_live + LW'(1);
                            n_res.status       = ST_OK;
                            n_res.given_handle = HW'(w_free.idx) + HW'(1);
                            n_res.slot         = r_live[SW-1:0];
                            n_res.live_count   = r_live + LW'(1);
                        end else begin
                            n_res.status = ST_FULL;
                        end
                    end else if (w_rm_ok) begin
                        n_state = S_REMOVE;
                    end else begin
                        n_res_valid      = 1'b1;
                        n_res            = '0;
                        n_res.status     = ST_UNKNOWN;
                        n_res.live_count = r_live;
                    end
                end
            end
            S_REMOVE: begin
                n_res_valid      = 1'b1;
                n_res            = '0;
                n_res.status     = ST_OK;
                n_res.slot       = r_rd_rem;
                n_res.live_count = w_live_m1;
                // move the last entry into the freed slot
                if (w_moved) begin
                    has_we             = 1'b1;
                    has_addr           = r_rd_rem;
                    has_data           = r_rd_lh;
                    soh_we             = 1'b1;
                    soh_addr           = w_lh_m1[SW-1:0];
                    soh_data           = r_rd_rem;
                    n_res.moved        = 1'b1;
                    n_res.moved_handle = r_rd_lh;
                    n_res.moved_from   = r_last;
                end
                n_in_use[r_hidx] = 1'b0;
                n_live           = w_live_m1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_live      <= '0;
            r_in_use    <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_live      <= n_live;
            r_in_use    <= n_in_use;
            r_res_valid <= n_res_valid;
        end
        r_res <= n_res;
    end

    // remove context, captured at acceptance
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hidx <= w_hidx;
            r_last <= w_last;
        end
    end

    // handle-at-slot RAM
    always_ff @(posedge i_clk) begin
        if (has_we) begin
            mem_has[has_addr] <= has_data;
        end
        r_rd_lh <= mem_has[w_last];
    end

    // slot-of-handle RAM
    always_ff @(posedge i_clk) begin
        if (soh_we) begin
            mem_soh[soh_addr] <= soh_data;
        end
        r_rd_rem <= mem_soh[w_hidx];
    end

`ifndef SYNTHESIS
    // bitmap population tracks the live count
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_in_use) == int'(r_live))
        else $error("in-use bitmap disagrees with live count");

    // busy always drops straight after the remove swap state
    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // an accepted add gives its beat in the next cycle
    a_add_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_cmd.kind == KIND_ADD) |=> o_res_valid)
        else $error("add gave no result beat");

    // the swap cycle gives its beat in the next cycle, with status ok
    a_rm_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_res_valid && o_res.status == ST_OK))
        else $error("remove gave no ok result beat");

    // live count never passes the table depth
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= LW'(MAX_ENTRIES))
        else $error("live count above table depth");
`endif

endmodule
`default_nettype wire
